FILE: hw/rtl/lru_tlb_lookup_assert.svh
// ----------------------------------------------------------------------------
// lru_tlb_lookup assertion macros
// Concurrent property shorthands for the translation buffer checks.
// ----------------------------------------------------------------------------
`ifndef LRU_TLB_LOOKUP_ASSERT_SVH
`define LRU_TLB_LOOKUP_ASSERT_SVH

// same-cycle implication
`define LRUTLB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_tlb_lookup check failed");

// next-cycle implication
`define LRUTLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_tlb_lookup check failed");

`endif

FILE: hw/rtl/lrutlb_pkg.sv
// ----------------------------------------------------------------------------
// lrutlb_pkg
// Types, constants and helpers shared by the translation buffer modules.
// ----------------------------------------------------------------------------
package lrutlb_pkg;

   localparam int VADDR_W = 32;
   localparam int VPAGE_W = 24;
   localparam int PPAGE_W = 24;
   localparam int CNT_W   = 32;
   localparam int IDX_W   = 5;
   localparam int SLOT_W  = 4;

   localparam logic [IDX_W-1:0]   ENTRIES_RESET = 5'd16;
   localparam logic [PPAGE_W-1:0] MASK_SMALL    = 24'hFFF0FF;
   localparam logic [PPAGE_W-1:0] MASK_LARGE    = 24'h0FFF0F;

   typedef enum logic {
      CSR_LARGE_PAGES    = 1'b0,
      CSR_ENTRIES_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [VADDR_W-1:0] vaddr;
      logic               is_data;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [PPAGE_W-1:0] phys_page;
      logic [VADDR_W-1:0] phys_addr;
      logic [SLOT_W-1:0]  slot;
      logic [CNT_W-1:0]   data_hit_count;
      logic [CNT_W-1:0]   data_miss_count;
      logic [CNT_W-1:0]   inst_hit_count;
      logic [CNT_W-1:0]   inst_miss_count;
      logic [CNT_W-1:0]   walk_count;
   } rsp_type;

   // search beat walking down the cell row
   typedef struct packed {
      logic               valid;
      logic [VPAGE_W-1:0] vpage;
      logic               hit;
      logic [IDX_W-1:0]   hit_slot;
      logic [IDX_W-1:0]   hit_rank;
      logic [PPAGE_W-1:0] hit_ppage;
      logic               free_found;
      logic [IDX_W-1:0]   free_slot;
      logic [IDX_W-1:0]   min_rank;
      logic [IDX_W-1:0]   min_slot;
   } token_type;

   // update broadcast to every cell
   typedef struct packed {
      logic               apply;
      logic               hit;
      logic [IDX_W-1:0]   slot;
      logic [IDX_W-1:0]   thr;
      logic               all_above;
      logic [IDX_W-1:0]   top_rank;
      logic [VPAGE_W-1:0] vpage;
      logic [PPAGE_W-1:0] ppage;
   } upd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

FILE: hw/rtl/lrutlb_cell.sv
// ----------------------------------------------------------------------------
// lrutlb_cell
// One buffer entry: match, free and victim search stage plus rank update.
// ----------------------------------------------------------------------------
module lrutlb_cell import lrutlb_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] n_i,
   input  token_type        tok_i,
   output token_type        tok_o,
   input  upd_type          upd_i
);

   logic               valid_ff, valid_in;
   logic [IDX_W-1:0]   rank_ff, rank_in;
   logic [VPAGE_W-1:0] vpage_ff;
   logic [PPAGE_W-1:0] ppage_ff;
   logic               tok_vld_ff;
   token_type          tok_ff, tok_in;
   logic               active;
   logic               mine;

   assign active = (IDX < int'(n_i));
   assign mine   = active && (upd_i.slot == IDX_W'(IDX));

   always_comb begin
      tok_in = tok_i;
      if (active) begin
         if (valid_ff && !tok_i.hit && (vpage_ff == tok_i.vpage)) begin
            tok_in.hit       = 1'b1;
            tok_in.hit_slot  = IDX_W'(IDX);
            tok_in.hit_rank  = rank_ff;
            tok_in.hit_ppage = ppage_ff;
         end
         if (!valid_ff && !tok_i.free_found) begin
            tok_in.free_found = 1'b1;
            tok_in.free_slot  = IDX_W'(IDX);
         end
         if ((IDX == 0) || (rank_ff < tok_i.min_rank)) begin
            tok_in.min_rank = rank_ff;
            tok_in.min_slot = IDX_W'(IDX);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd_i.apply && active) begin
         if (valid_ff && (upd_i.all_above || (rank_ff > upd_i.thr)) && (rank_ff != '0)) begin
            rank_in = rank_ff - IDX_W'(1);
         end
         if (mine) begin
            rank_in  = upd_i.top_rank;
            valid_in = valid_ff | !upd_i.hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         rank_ff    <= '0;
         tok_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rank_ff    <= rank_in;
         tok_vld_ff <= tok_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_i.apply && mine && !upd_i.hit) begin
         vpage_ff <= upd_i.vpage;
         ppage_ff <= upd_i.ppage;
      end
      if (tok_i.valid) begin
         tok_ff <= tok_in;
      end
   end

   always_comb begin
      tok_o       = tok_ff;
      tok_o.valid = tok_vld_ff;
   end

endmodule

FILE: hw/rtl/lru_tlb_lookup.sv
// ----------------------------------------------------------------------------
// lru_tlb_lookup
// Fully associative translation buffer with rank-counter LRU replacement.
// ----------------------------------------------------------------------------
// A request beat carries a virtual address and an access kind on req_*.
// The lookup beat walks down a row of ENTRIES cells, one cell per cycle;
// each cell checks its own entry for a match, a free slot and the lowest
// rank. After the last cell, the update cycle broadcasts the rank, fill
// and counter changes and loads the response register.
// req_ready is high only while no lookup is in flight, and a new request
// may be taken while a response still waits.
// If the receiver stalls, the response holds and the update cycle waits
// until the response register frees up.
// Reset clears all valid bits, ranks, counters and the CSRs (small
// pages, 16 entries in use). Entry tags and pages are not cleared.
// CSRs are written through csr_* only while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lru_tlb_lookup import lrutlb_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [IDX_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic               large_ff;
   logic [IDX_W-1:0]   entries_ff;
   logic [IDX_W-1:0]   n_act;
   req_type            req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic [CNT_W-1:0]   dhit_ff, dmiss_ff, ihit_ff, imiss_ff, walks_ff;
   logic [CNT_W-1:0]   dhit_in, dmiss_in, ihit_in, imiss_in, walks_in;
   token_type          tok [ENTRIES+1];
   logic [ENTRIES-1:0] tok_vld;
   token_type          last;
   upd_type            upd;
   logic               accept;
   logic               fire;
   logic [PPAGE_W-1:0] walk_ppage;
   logic [PPAGE_W-1:0] ppage;
   logic [VPAGE_W-1:0] req_vpage;

   assign n_act = (entries_ff == '0) ? IDX_W'(1) :
                  ((int'(entries_ff) > ENTRIES) ? IDX_W'(ENTRIES) : entries_ff);

   assign req_vpage = large_ff ? {4'b0, req_data.vaddr[31:12]} : req_data.vaddr[31:8];
   assign accept    = req_valid && req_ready;

   always_comb begin
      tok[0]            = '0;
      tok[0].valid      = accept;
      tok[0].vpage      = req_vpage;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lrutlb_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .reset (reset),
         .n_i   (n_act),
         .tok_i (tok[i]),
         .tok_o (tok[i+1]),
         .upd_i (upd)
      );
      assign tok_vld[i] = tok[i+1].valid;
   end

   assign last = tok[ENTRIES];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SEARCH;
         ST_SEARCH: if (last.valid) state_in = ST_UPDATE;
         ST_UPDATE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SEARCH: ;
         ST_UPDATE: fire = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign walk_ppage = ~last.vpage & (large_ff ? MASK_LARGE : MASK_SMALL);
   assign ppage      = last.hit ? last.hit_ppage : walk_ppage;

   always_comb begin
      upd           = '0;
      upd.apply     = fire;
      upd.hit       = last.hit;
      upd.slot      = last.hit ? last.hit_slot :
                      (last.free_found ? last.free_slot : last.min_slot);
      upd.thr       = last.hit ? last.hit_rank : last.min_rank;
      upd.all_above = !last.hit && last.free_found;
      upd.top_rank  = n_act - IDX_W'(1);
      upd.vpage     = last.vpage;
      upd.ppage     = walk_ppage;
   end

   always_comb begin
      dhit_in  = dhit_ff;
      dmiss_in = dmiss_ff;
      ihit_in  = ihit_ff;
      imiss_in = imiss_ff;
      walks_in = walks_ff;
      if (last.hit) begin
         if (req_ff.is_data) dhit_in = sat_inc(dhit_ff);
         else                ihit_in = sat_inc(ihit_ff);
      end else begin
         walks_in = sat_inc(walks_ff);
         if (req_ff.is_data) dmiss_in = sat_inc(dmiss_ff);
         else                imiss_in = sat_inc(imiss_ff);
      end
   end

   always_comb begin
      rsp_in                 = '0;
      rsp_in.hit             = last.hit;
      rsp_in.phys_page       = ppage;
      rsp_in.phys_addr       = large_ff ? {ppage[19:0], req_ff.vaddr[11:0]} :
                                          {ppage[23:0], req_ff.vaddr[7:0]};
      rsp_in.slot            = upd.slot[SLOT_W-1:0];
      rsp_in.data_hit_count  = dhit_in;
      rsp_in.data_miss_count = dmiss_in;
      rsp_in.inst_hit_count  = ihit_in;
      rsp_in.inst_miss_count = imiss_in;
      rsp_in.walk_count      = walks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         large_ff     <= 1'b0;
         entries_ff   <= ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
         dhit_ff      <= '0;
         dmiss_ff     <= '0;
         ihit_ff      <= '0;
         imiss_ff     <= '0;
         walks_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_LARGE_PAGES:    large_ff   <= csr_wdata[0];
               CSR_ENTRIES_IN_USE: entries_ff <= csr_wdata;
               default:            ;
            endcase
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            dhit_ff      <= dhit_in;
            dmiss_ff     <= dmiss_in;
            ihit_ff      <= ihit_in;
            imiss_ff     <= imiss_in;
            walks_ff     <= walks_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "lru_tlb_lookup_assert.svh"

   `LRUTLB_ASSERT_NOW(a_one_beat_in_row, clock, reset, 1'b1, $onehot0(tok_vld))
   `LRUTLB_ASSERT_NEXT(a_fire_loads_rsp, clock, reset, fire, rsp_valid && (state_ff == ST_IDLE))
   `LRUTLB_ASSERT_NEXT(a_miss_counts_walk, clock, reset, fire && !last.hit,
      (walks_ff != $past(walks_ff)) || (walks_ff == '1))

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// lru_tlb_lookup testbench
// Drives lookups through the request channel and scores every response
// against a cycle-free model of the translation buffer: tag match, rank
// LRU update, fill of free or least recently used slots, mock walk and
// the saturating access counters. Directed cases cover fills, hits,
// evictions, entry count limits, duplicate tags and page size changes;
// random traffic mixes a reused page set with arbitrary addresses under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import lrutlb_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int IDLE_LIMIT = 4000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = 1'b0;
   logic [IDX_W-1:0] csr_wdata = '0;

   lru_tlb_lookup #(.ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // translation buffer model state
   logic [VPAGE_W-1:0] tag_tab   [ENTRIES];
   logic [PPAGE_W-1:0] frame_tab [ENTRIES];
   bit                 valid_tab [ENTRIES] = '{default: 1'b0};
   logic [3:0]         rank_tab  [ENTRIES] = '{default: 4'd0};
   logic [CNT_W-1:0]   data_hits   = '0;
   logic [CNT_W-1:0]   data_misses = '0;
   logic [CNT_W-1:0]   inst_hits   = '0;
   logic [CNT_W-1:0]   inst_misses = '0;
   logic [CNT_W-1:0]   walks       = '0;
   logic               large_cfg   = 1'b0;
   logic [IDX_W-1:0]   entries_cfg = ENTRIES_RESET;

   rsp_type pending_translations[$];

   int errors      = 0;
   int lookups     = 0;
   int hits_seen   = 0;
   int csr_writes  = 0;
   int burst_left  = 0;
   int ready_run   = 0;
   int idle_cycles = 0;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   function automatic rsp_type predict_translation(input req_type item);
      rsp_type     res;
      logic [31:0] vpage, offset, ppage;
      int          shift, n, slot, i;
      bit          hit, found_free;
      logic [3:0]  thr;
      shift  = large_cfg ? 12 : 8;
      vpage  = item.vaddr >> shift;
      offset = item.vaddr & ((32'd1 << shift) - 1);
      n      = (entries_cfg == 0) ? 1 : ((entries_cfg > ENTRIES) ? ENTRIES : int'(entries_cfg));
      hit    = 1'b0;
      slot   = 0;
      for (i = 0; i < n; i++) begin
         if (!hit && valid_tab[i] && {8'd0, tag_tab[i]} == vpage) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         thr = rank_tab[slot];
         for (i = 0; i < n; i++)
            if (valid_tab[i] && rank_tab[i] > thr && rank_tab[i] > 0)
               rank_tab[i] = rank_tab[i] - 4'd1;
         rank_tab[slot] = 4'(n - 1);
         ppage = {8'd0, frame_tab[slot]};
         if (item.is_data) data_hits = bump(data_hits);
         else inst_hits = bump(inst_hits);
      end else begin
         ppage = ~vpage & (large_cfg ? {8'd0, MASK_LARGE} : {8'd0, MASK_SMALL});
         walks = bump(walks);
         if (item.is_data) data_misses = bump(data_misses);
         else inst_misses = bump(inst_misses);
         found_free = 1'b0;
         for (i = 0; i < n; i++) begin
            if (!found_free && !valid_tab[i]) begin
               found_free = 1'b1;
               slot       = i;
            end
         end
         if (found_free) begin
            for (i = 0; i < n; i++)
               if (valid_tab[i] && rank_tab[i] > 0)
                  rank_tab[i] = rank_tab[i] - 4'd1;
         end else begin
            slot = 0;
            for (i = 1; i < n; i++)
               if (rank_tab[i] < rank_tab[slot])
                  slot = i;
            thr = rank_tab[slot];
            for (i = 0; i < n; i++)
               if (valid_tab[i] && rank_tab[i] > thr && rank_tab[i] > 0)
                  rank_tab[i] = rank_tab[i] - 4'd1;
         end
         valid_tab[slot] = 1'b1;
         tag_tab[slot]   = vpage[VPAGE_W-1:0];
         frame_tab[slot] = ppage[PPAGE_W-1:0];
         rank_tab[slot]  = 4'(n - 1);
      end
      res.hit             = hit;
      res.phys_page       = ppage[PPAGE_W-1:0];
      res.phys_addr       = (ppage << shift) | offset;
      res.slot            = 4'(slot);
      res.data_hit_count  = data_hits;
      res.data_miss_count = data_misses;
      res.inst_hit_count  = inst_hits;
      res.inst_miss_count = inst_misses;
      res.walk_count      = walks;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch on %s: got %h, want %h (response %0d)", field, got, want,
               lookups - pending_translations.size());
   endtask

   task automatic send_lookup(input logic [31:0] va, input logic kind);
      req_type item;
      rsp_type want;
      int      gap;
      item.vaddr   = va;
      item.is_data = kind;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want = predict_translation(item);
      pending_translations.push_back(want);
      lookups++;
      if (want.hit) hits_seen++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [IDX_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LARGE_PAGES) large_cfg = value[0];
      else entries_cfg = value;
      csr_writes++;
   endtask

   task automatic test_fill_and_hit;
      write_csr(CSR_LARGE_PAGES, 5'b00000);
      write_csr(CSR_ENTRIES_IN_USE, 5'd4);
      send_lookup(32'h0000_0000, 1'b0);
      send_lookup(32'h0000_1234, 1'b1);
      send_lookup(32'h0000_2311, 1'b0);
      send_lookup(32'hFFFF_FFFF, 1'b1);
      send_lookup(32'h0000_1299, 1'b0);
      send_lookup(32'hFFFF_FF00, 1'b1);
      send_lookup(32'h0077_7777, 1'b0);
   endtask

   task automatic test_duplicate_tags;
      write_csr(CSR_ENTRIES_IN_USE, 5'd5);
      send_lookup(32'h00AB_CD00, 1'b1);
      write_csr(CSR_ENTRIES_IN_USE, 5'd2);
      send_lookup(32'h00AB_CD01, 1'b0);
      write_csr(CSR_ENTRIES_IN_USE, 5'd16);
      send_lookup(32'h00AB_CD02, 1'b1);
   endtask

   task automatic test_entry_limits;
      write_csr(CSR_ENTRIES_IN_USE, 5'd0);
      send_lookup(32'h0000_0100, 1'b0);
      send_lookup(32'h0000_0200, 1'b1);
      send_lookup(32'h0000_0200, 1'b0);
      write_csr(CSR_ENTRIES_IN_USE, 5'd31);
      send_lookup(32'h0030_0000, 1'b1);
      send_lookup(32'h00AB_CD00, 1'b0);
   endtask

   task automatic test_page_size_switch;
      write_csr(CSR_LARGE_PAGES, 5'b11111);
      send_lookup(32'h1234_5678, 1'b1);
      send_lookup(32'h1234_5ABC, 1'b0);
      write_csr(CSR_LARGE_PAGES, 5'b11110);
      send_lookup(32'h0123_4500, 1'b1);
   endtask

   task automatic test_random_traffic;
      logic [VPAGE_W-1:0] pool [24];
      logic [31:0]        va;
      int                 k, j, sel, span, phase;
      for (j = 0; j < 24; j++) pool[j] = 24'($urandom);
      span = 8;
      for (k = 0; k < 700; k++) begin
         if (k % 100 == 0) begin
            phase = k / 100;
            write_csr(CSR_LARGE_PAGES,
                      {4'($urandom), (phase < 2) ? phase[0] : 1'($urandom_range(0, 1))});
            case (phase)
               0: write_csr(CSR_ENTRIES_IN_USE, 5'd16);
               1: write_csr(CSR_ENTRIES_IN_USE, 5'd1);
               2: write_csr(CSR_ENTRIES_IN_USE, 5'd31);
               3: write_csr(CSR_ENTRIES_IN_USE, 5'd0);
               4: write_csr(CSR_ENTRIES_IN_USE, 5'd2);
               default: write_csr(CSR_ENTRIES_IN_USE, 5'($urandom_range(0, 31)));
            endcase
            span = $urandom_range(2, 24);
         end
         j = $urandom_range(0, span - 1);
         if ($urandom_range(0, 19) == 0) pool[j] = 24'($urandom);
         sel = $urandom_range(0, 19);
         if (sel == 0) va = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         else if (sel <= 5) va = $urandom;
         else if (large_cfg) va = {pool[j][19:0], 12'($urandom)};
         else va = {pool[j], 8'($urandom)};
         send_lookup(va, 1'($urandom_range(0, 1)));
      end
   endtask

   // receiver: alternate long ready stretches, short bursts and stalls
   always @(posedge clock) begin
      if (ready_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b1;
               ready_run = $urandom_range(20, 80);
            end
            1: begin
               rsp_ready <= 1'b0;
               ready_run = $urandom_range(1, 25);
            end
            default: begin
               rsp_ready <= 1'b1;
               ready_run = $urandom_range(1, 6);
            end
         endcase
      end else begin
         ready_run--;
      end
   end

   // score each response beat against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_translations.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.phys_addr, 32'h0);
         end else begin
            want = pending_translations.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 32'(rsp_data.hit), 32'(want.hit));
            if (rsp_data.phys_page !== want.phys_page)
               report_mismatch("phys_page", 32'(rsp_data.phys_page), 32'(want.phys_page));
            if (rsp_data.phys_addr !== want.phys_addr)
               report_mismatch("phys_addr", rsp_data.phys_addr, want.phys_addr);
            if (rsp_data.slot !== want.slot)
               report_mismatch("slot", 32'(rsp_data.slot), 32'(want.slot));
            if (rsp_data.data_hit_count !== want.data_hit_count)
               report_mismatch("data_hit_count", rsp_data.data_hit_count,
                               want.data_hit_count);
            if (rsp_data.data_miss_count !== want.data_miss_count)
               report_mismatch("data_miss_count", rsp_data.data_miss_count,
                               want.data_miss_count);
            if (rsp_data.inst_hit_count !== want.inst_hit_count)
               report_mismatch("inst_hit_count", rsp_data.inst_hit_count,
                               want.inst_hit_count);
            if (rsp_data.inst_miss_count !== want.inst_miss_count)
               report_mismatch("inst_miss_count", rsp_data.inst_miss_count,
                               want.inst_miss_count);
            if (rsp_data.walk_count !== want.walk_count)
               report_mismatch("walk_count", rsp_data.walk_count, want.walk_count);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_and_hit();
      test_duplicate_tags();
      test_entry_limits();
      test_page_size_switch();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (ENTRIES + 4) @(posedge clock);
      $display("covered %0d lookups (%0d hits, %0d misses) and %0d register writes",
               lookups, hits_seen, lookups - hits_seen, csr_writes);
      $display("both page sizes, entry counts 0 to 31, duplicate tags, %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
